>>> rtl/vas_pkg.sv
// Package for the voice allocator and stepper.
// Holds operation and status codes and the shared control struct.
// No dependencies.
package vas_pkg;

  localparam int OP_W = 2;
  localparam logic [1:0] OP_CLAIM = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  // The fourth operation code does nothing.
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STOLEN  = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  localparam int LEN_W  = 24;
  localparam int RATE_W = 24;
  localparam int VOL_W  = 8;
  localparam logic [VOL_W-1:0] VOL_MAX = 8'd255;

  // Request from the sequencer to the per-voice update unit.
  typedef struct packed {
    logic looping;
    logic active;
  } upd_ctl_t;

endpackage

>>> rtl/vas_update.sv
// Per-voice tick update: add rate to position, then clamp in one-shot mode.
// Depends on vas_pkg. Purely combinational step of the shared unit;
// the looping remainder comes from the vas_divider.
module vas_update #(
  parameter int POS_W = 41,
  parameter int FRAC_BITS = 16
) (
  input  vas_pkg::upd_ctl_t          ctl,
  input  logic signed [POS_W-1:0]    pos,
  input  logic signed [vas_pkg::RATE_W-1:0] rate,
  input  logic [vas_pkg::LEN_W-1:0]  len,
  output logic signed [POS_W-1:0]    sum,
  output logic signed [POS_W-1:0]    clamped,
  output logic                       ended
);
  logic signed [POS_W-1:0] lim;

  always_comb begin
    lim = {{(POS_W - vas_pkg::LEN_W - FRAC_BITS){1'b0}}, len, {FRAC_BITS{1'b0}}};
    sum = pos + POS_W'(rate);
    clamped = sum;
    ended = 1'b0;
    if (ctl.active && !ctl.looping) begin
      if (sum > lim) begin
        clamped = lim;
        ended = 1'b1;
      end else if (sum < -lim) begin
        clamped = -lim;
        ended = 1'b1;
      end
    end
  end
endmodule

>>> rtl/vas_divider.sv
// Restoring divider for the looping wrap: remainder of |a| by d, one bit a cycle.
// No dependencies; sign of result follows the dividend.
module vas_divider #(
  parameter int POS_W = 41
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [POS_W-1:0] dividend,
  input  logic [POS_W-1:0]        divisor,
  output logic                    done,
  output logic signed [POS_W-1:0] remainder
);
  localparam int CW = $clog2(POS_W + 1);
  logic [POS_W-1:0] quo;
  logic [POS_W:0]   rem;
  logic [POS_W-1:0] dv;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [POS_W:0]   trial;

  assign trial = {rem[POS_W-1:0], quo[POS_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dividend[POS_W-1];
        quo  <= dividend[POS_W-1] ? POS_W'(-dividend) : POS_W'(dividend);
        dv   <= divisor;
        rem  <= '0;
        cnt  <= CW'(POS_W);
      end else if (busy) begin
        quo <= {quo[POS_W-2:0], 1'b0};
        if (trial >= {1'b0, dv}) begin
          rem <= trial - {1'b0, dv};
        end else begin
          rem <= trial;
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = neg ? -$signed(rem[POS_W-1:0]) : $signed(rem[POS_W-1:0]);
endmodule

>>> rtl/voice_allocator_stepper_top.sv
// Voice allocator and stepper: the per-voice table walk and its sequencer.
// Input channel: in_valid/in_stall with operation, voice_index and sound fields;
// output channel: out_valid/out_stall with status, chosen_voice and counts.
// cfg_we/cfg_wdata write the config register looping, which the user must
// write only while idle; the block does not enforce it. Claim and tick items
// walk the voice table one voice per step through a single update unit and a
// one-port memory per store (read, then update, then write). Claim: S_FREE per
// voice searched, then S_STEAL_RD and S_STEAL_CMP per voice if none is free,
// then S_START. Stop: done in S_IDLE. Tick: S_TICK_RD per idle voice, S_TICK_RD
// and S_TICK_UPD per active voice in one-shot mode; in looping mode an active
// voice also runs the bit-serial divider (S_TICK_DIV, S_TICK_WAIT). Every item
// then passes S_DONE to raise out_valid. The walk is set by the voice memories'
// single read port and the divider. Only one item is in work at a time;
// in_stall is high from acceptance until the result word is taken. A stalled
// result holds until out_stall drops. Reset (rst, synchronous) clears all
// active bits, sets looping to zero and zeroes positions by a clearing pass
// over every voice (S_CLEAR) during which no word is accepted.
// Dependencies: vas_pkg, vas_update, vas_divider.
module voice_allocator_stepper_top #(
  parameter int NUM_VOICES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [5:0]  voice_index,
  input  logic        sound_present,
  input  logic [23:0] sound_length,
  input  logic [7:0]  start_volume,
  input  logic signed [23:0] step_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  chosen_voice,
  output logic [6:0]  ended_count,
  output logic [6:0]  active_count
);
  // Two bits above the length field so that position plus rate cannot overflow.
  localparam int POS_W = vas_pkg::LEN_W + FRAC_BITS + 2;
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FREE, S_STEAL_RD, S_STEAL_CMP, S_START,
    S_TICK_RD, S_TICK_UPD, S_TICK_DIV, S_TICK_WAIT, S_DONE
  } state_t;

  state_t state;
  logic looping;
  logic [NUM_VOICES-1:0] active;
  logic signed [POS_W-1:0] pos_mem [NUM_VOICES];
  logic signed [vas_pkg::RATE_W-1:0] rate_mem [NUM_VOICES];
  logic [vas_pkg::LEN_W-1:0] len_mem [NUM_VOICES];
  logic [vas_pkg::VOL_W-1:0] vol_mem [NUM_VOICES];

  logic [VW-1:0] idx;
  logic [VW-1:0] pick;
  logic          found;
  logic [POS_W-1:0] best_abs;
  logic [vas_pkg::VOL_W-1:0] best_vol;
  logic [CW-1:0] act_cnt;
  logic [CW-1:0] end_cnt;

  logic [1:0]  op_r;
  logic [23:0] len_r;
  logic [7:0]  vol_r;
  logic signed [23:0] rate_r;

  logic signed [POS_W-1:0] rd_pos;
  logic signed [vas_pkg::RATE_W-1:0] rd_rate;
  logic [vas_pkg::LEN_W-1:0] rd_len;
  logic [vas_pkg::VOL_W-1:0] rd_vol;
  logic signed [POS_W-1:0] sum_r;
  logic [vas_pkg::LEN_W-1:0] lenq_r;

  logic signed [POS_W-1:0] sum, clamped, rem;
  logic ended, div_done, div_start;
  vas_pkg::upd_ctl_t uctl;
  logic [POS_W-1:0] abs_pos;
  logic last;

  assign uctl.looping = looping;
  assign uctl.active = 1'b1;
  assign abs_pos = rd_pos[POS_W-1] ? POS_W'(-rd_pos) : POS_W'(rd_pos);
  assign last = (idx == VW'(NUM_VOICES - 1));
  assign div_start = (state == S_TICK_DIV);

  vas_update #(.POS_W(POS_W), .FRAC_BITS(FRAC_BITS)) u_upd (
    .ctl(uctl), .pos(rd_pos), .rate(rd_rate), .len(rd_len),
    .sum(sum), .clamped(clamped), .ended(ended)
  );

  vas_divider #(.POS_W(POS_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_r),
    .divisor(POS_W'({lenq_r, FRAC_BITS'(0)})), .done(div_done), .remainder(rem)
  );

  // Single-port reads of the voice stores at the walk index.
  always_ff @(posedge clk) begin
    rd_pos  <= pos_mem[idx];
    rd_rate <= rate_mem[idx];
    rd_len  <= len_mem[idx];
    rd_vol  <= vol_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      looping <= 1'b0;
      active <= '0;
      idx <= '0;
      out_valid <= 1'b0;
      act_cnt <= '0;
    end else begin
      if (cfg_we) begin
        looping <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          pos_mem[idx] <= '0;
          if (last) begin
            idx <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r <= operation;
            len_r <= sound_length;
            vol_r <= start_volume;
            rate_r <= step_rate;
            idx <= '0;
            found <= 1'b0;
            best_abs <= '0;
            best_vol <= vas_pkg::VOL_MAX;
            end_cnt <= '0;
            status <= vas_pkg::ST_OK;
            chosen_voice <= '0;
            case (operation)
              vas_pkg::OP_CLAIM: begin
                if (!sound_present) begin
                  status <= vas_pkg::ST_MISSING;
                  state <= S_DONE;
                end else begin
                  state <= S_FREE;
                end
              end
              vas_pkg::OP_STOP: begin
                if ({3'b0, voice_index} < 9'(NUM_VOICES) && active[VW'(voice_index)]) begin
                  active[VW'(voice_index)] <= 1'b0;
                  act_cnt <= act_cnt - 1'b1;
                end
                state <= S_DONE;
              end
              vas_pkg::OP_TICK: state <= S_TICK_RD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_FREE: begin
          if (!active[idx]) begin
            pick <= idx;
            state <= S_START;
          end else if (last) begin
            idx <= '0;
            status <= vas_pkg::ST_STOLEN;
            state <= S_STEAL_RD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_STEAL_RD: state <= S_STEAL_CMP;
        S_STEAL_CMP: begin
          if (looping) begin
            if (rd_vol < best_vol) begin
              best_vol <= rd_vol;
              pick <= idx;
              found <= 1'b1;
            end
          end else if (abs_pos > best_abs) begin
            best_abs <= abs_pos;
            pick <= idx;
            found <= 1'b1;
          end
          if (last) begin
            state <= S_START;
          end else begin
            idx <= idx + 1'b1;
            state <= S_STEAL_RD;
          end
        end
        S_START: begin
          if (status == vas_pkg::ST_STOLEN && !found) begin
            status <= vas_pkg::ST_NONE;
          end else begin
            if (!active[pick]) begin
              act_cnt <= act_cnt + 1'b1;
            end
            active[pick] <= 1'b1;
            pos_mem[pick] <= '0;
            rate_mem[pick] <= rate_r;
            len_mem[pick] <= len_r;
            vol_mem[pick] <= vol_r;
            chosen_voice <= 6'(pick);
          end
          state <= S_DONE;
        end
        S_TICK_RD: begin
          if (!active[idx]) begin
            if (last) begin
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            state <= S_TICK_UPD;
          end
        end
        S_TICK_UPD: begin
          if (looping) begin
            sum_r <= sum;
            lenq_r <= rd_len;
            state <= S_TICK_DIV;
          end else begin
            pos_mem[idx] <= clamped;
            if (ended) begin
              active[idx] <= 1'b0;
              act_cnt <= act_cnt - 1'b1;
              end_cnt <= end_cnt + 1'b1;
            end
            if (last) begin
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
              state <= S_TICK_RD;
            end
          end
        end
        S_TICK_DIV: state <= S_TICK_WAIT;
        S_TICK_WAIT: begin
          if (div_done) begin
            pos_mem[idx] <= (lenq_r == '0) ? '0 : rem;
            if (last) begin
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
              state <= S_TICK_RD;
            end
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            ended_count <= 7'(end_cnt);
            active_count <= 7'(act_cnt);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (act_cnt == CW'($countones(active))))
    else $error("active count out of step with active bits");
  a_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result word repeated");
  a_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && op_r != vas_pkg::OP_TICK) |-> (ended_count == 7'd0))
    else $error("ended count set outside a tick");
`endif
endmodule
